### rtl/fsl_pkg.sv
// ----------------------------------------------------------------------------
// fsl_pkg
// Shared types, codes and helpers for the FM seek and lock controller.
// ----------------------------------------------------------------------------
package fsl_pkg;

  localparam int unsigned FREQ_W = 14;
  localparam int unsigned DEV_W  = 12;
  localparam int unsigned CFG_ADDR_W = 2;

  localparam logic [FREQ_W-1:0] LOW_LIMIT_RST  = 14'd8750;
  localparam logic [FREQ_W-1:0] HIGH_LIMIT_RST = 14'd10800;
  localparam logic [FREQ_W-1:0] CUR_FREQ_RST   = 14'd8750;

  // Measurement thresholds.
  localparam logic [3:0]       SNR_MIN_REJ  = 4'd2;
  localparam logic [7:0]       RSSI_MIN     = 8'd10;
  localparam logic [DEV_W-1:0] DEV_BAND_LO  = 12'd280;
  localparam logic [DEV_W-1:0] DEV_BAND_HI  = 12'd3815;
  localparam logic [DEV_W-1:0] DEV_NEIGH_LO = 12'd20;
  localparam logic [DEV_W-1:0] DEV_NEIGH_HI = 12'd4075;
  localparam int unsigned      DEV_SIGN_BIT = 11;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LOW_LIMIT   = 2'd0,
    CFG_HIGH_LIMIT  = 2'd1,
    CFG_MANUAL_MODE = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    OP_MOVE = 1'b0,
    OP_MEAS = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_TUNE    = 2'd0,
    KIND_STEP    = 2'd1,
    KIND_FOUND   = 2'd2,
    KIND_RESTORE = 2'd3
  } kind_t;

  typedef struct packed {
    logic             op;
    logic             dir_down;
    logic [3:0]       snr;
    logic             afc_railed;
    logic [7:0]       rssi;
    logic [DEV_W-1:0] deviation;
  } fsl_in_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [FREQ_W-1:0] freq;
  } fsl_out_t;

  // Next frequency one unit up or down, wrapped between the band limits.
  function automatic logic [FREQ_W-1:0] wrap_next(
    input logic [FREQ_W-1:0] f,
    input logic              down,
    input logic [FREQ_W-1:0] lo,
    input logic [FREQ_W-1:0] hi
  );
    logic [FREQ_W-1:0] n;
    n = down ? (f - 1'b1) : (f + 1'b1);
    if (n < lo) n = hi;
    if (n > hi) n = lo;
    return n;
  endfunction

endpackage

### rtl/fm_seek_lock_controller.sv
// ----------------------------------------------------------------------------
// fm_seek_lock_controller
// Seek and single-step control for an FM tuner, judged by measurement reports.
// ----------------------------------------------------------------------------
// Each input transfer is either a move command or a measurement report for the
// last tuned frequency, and is handled in the cycle it is accepted: the state
// registers and the single output register update at that clock edge, so one
// item is taken every cycle unless the output stalls, and its result, if any,
// is on the output in the next cycle. Only the output register throttles input:
// in_ready is low only while a result is held and out_ready is low. A move in
// manual mode steps the frequency by one unit (kind step done); otherwise it
// starts a seek and emits the first tune request. During a seek every
// measurement either locks (station found), ends the circle at the start
// frequency (restore the original frequency), or emits the next tune request.
// Moves during a seek and measurements outside a seek are consumed silently.
// Configuration writes take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module fm_seek_lock_controller
  import fsl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fsl_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fsl_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [FREQ_W-1:0]     cfg_wdata
);

  // Configuration registers.
  logic [FREQ_W-1:0] low_limit_r;
  logic [FREQ_W-1:0] high_limit_r;
  logic              manual_r;

  // Seek state.
  logic [FREQ_W-1:0] cur_freq_r,   cur_freq_nxt;
  logic [FREQ_W-1:0] seek_start_r, seek_start_nxt;
  logic [FREQ_W-1:0] try_freq_r,   try_freq_nxt;
  logic              seeking_r,    seeking_nxt;
  logic              seek_down_r,  seek_down_nxt;
  logic [FREQ_W-1:0] prev_freq_r,  prev_freq_nxt;
  logic [DEV_W-1:0]  prev_dev_r,   prev_dev_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  fsl_out_t          out_data_r,  out_data_nxt;

  logic              in_xfer;
  logic              lock_ok;
  logic [FREQ_W-1:0] step_freq;
  logic [FREQ_W-1:0] try_next;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The wrap from the current frequency serves both a manual step and the
  // first tune of a seek; the wrap from the try frequency continues a seek.
  assign step_freq = wrap_next(cur_freq_r, in_data.dir_down, low_limit_r, high_limit_r);
  assign try_next  = wrap_next(try_freq_r, seek_down_r, low_limit_r, high_limit_r);

  fsl_lock_judge u_judge (
    .meas      (in_data),
    .try_freq  (try_freq_r),
    .prev_freq (prev_freq_r),
    .prev_dev  (prev_dev_r),
    .low_limit (low_limit_r),
    .lock_ok   (lock_ok)
  );

  always_comb begin
    cur_freq_nxt   = cur_freq_r;
    seek_start_nxt = seek_start_r;
    try_freq_nxt   = try_freq_r;
    seeking_nxt    = seeking_r;
    seek_down_nxt  = seek_down_r;
    prev_freq_nxt  = prev_freq_r;
    prev_dev_nxt   = prev_dev_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;

    if (in_xfer) begin
      out_valid_nxt = 1'b0;
      if (in_data.op == OP_MOVE) begin
        if (!seeking_r) begin
          out_valid_nxt = 1'b1;
          if (manual_r) begin
            cur_freq_nxt = step_freq;
            out_data_nxt = '{kind: KIND_STEP, freq: step_freq};
          end else begin
            seeking_nxt    = 1'b1;
            seek_down_nxt  = in_data.dir_down;
            seek_start_nxt = cur_freq_r;
            try_freq_nxt   = step_freq;
            out_data_nxt   = '{kind: KIND_TUNE, freq: step_freq};
          end
        end
      end else if (seeking_r) begin
        out_valid_nxt = 1'b1;
        prev_dev_nxt  = in_data.deviation;
        prev_freq_nxt = try_freq_r;
        if (lock_ok) begin
          cur_freq_nxt = try_freq_r;
          seeking_nxt  = 1'b0;
          out_data_nxt = '{kind: KIND_FOUND, freq: try_freq_r};
        end else if (try_freq_r == seek_start_r) begin
          // Full circle without a lock: go back to where we started.
          seeking_nxt  = 1'b0;
          out_data_nxt = '{kind: KIND_RESTORE, freq: cur_freq_r};
        end else begin
          try_freq_nxt = try_next;
          out_data_nxt = '{kind: KIND_TUNE, freq: try_next};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_limit_r  <= LOW_LIMIT_RST;
      high_limit_r <= HIGH_LIMIT_RST;
      manual_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LOW_LIMIT:   low_limit_r  <= cfg_wdata;
        CFG_HIGH_LIMIT:  high_limit_r <= cfg_wdata;
        CFG_MANUAL_MODE: manual_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_freq_r   <= CUR_FREQ_RST;
      seek_start_r <= '0;
      try_freq_r   <= '0;
      seeking_r    <= 1'b0;
      seek_down_r  <= 1'b0;
      prev_freq_r  <= '0;
      prev_dev_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      cur_freq_r   <= cur_freq_nxt;
      seek_start_r <= seek_start_nxt;
      try_freq_r   <= try_freq_nxt;
      seeking_r    <= seeking_nxt;
      seek_down_r  <= seek_down_nxt;
      prev_freq_r  <= prev_freq_nxt;
      prev_dev_r   <= prev_dev_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // A held result blocks new input.
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !in_ready)
    else $error("input accepted while a result is stalled");

  // A measurement outside a seek produces nothing.
  a_idle_meas_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_data.op == OP_MEAS) && !seeking_r |=> !out_valid_r)
    else $error("result produced for a measurement outside a seek");

  // Starting a seek records the start frequency.
  a_seek_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_data.op == OP_MOVE) && !seeking_r && !manual_r
    |=> seeking_r && (seek_start_r == $past(cur_freq_r)))
    else $error("seek did not start correctly");

  // A lock ends the seek and reports the tried frequency.
  a_lock_ends_seek: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_data.op == OP_MEAS) && seeking_r && lock_ok
    |=> !seeking_r && out_valid_r && (out_data_r.kind == KIND_FOUND) &&
        (cur_freq_r == $past(try_freq_r)))
    else $error("lock did not end the seek");

endmodule

### rtl/fsl_lock_judge.sv
// ----------------------------------------------------------------------------
// fsl_lock_judge
// Decides whether a measured frequency is accepted as a locked station.
// ----------------------------------------------------------------------------
module fsl_lock_judge
  import fsl_pkg::*;
(
  input  fsl_in_t           meas,
  input  logic [FREQ_W-1:0] try_freq,
  input  logic [FREQ_W-1:0] prev_freq,
  input  logic [DEV_W-1:0]  prev_dev,
  input  logic [FREQ_W-1:0] low_limit,
  output logic              lock_ok
);

  logic [FREQ_W:0] prev_plus1;
  logic [FREQ_W:0] try_plus1;
  logic            basic_rej;
  logic            above_rej;
  logic            below_rej;

  assign prev_plus1 = {1'b0, prev_freq} + 1'b1;
  assign try_plus1  = {1'b0, try_freq} + 1'b1;

  assign basic_rej = (meas.snr <= SNR_MIN_REJ) || meas.afc_railed ||
                     (meas.rssi < RSSI_MIN) ||
                     ((meas.deviation >= DEV_BAND_LO) && (meas.deviation <= DEV_BAND_HI));

  // Previous frequency is the neighbor just below this one.
  assign above_rej = (try_freq > low_limit) && ({1'b0, try_freq} == prev_plus1) &&
                     (prev_dev[DEV_SIGN_BIT] || (prev_dev < DEV_NEIGH_LO));

  // Previous frequency is the neighbor just above this one.
  assign below_rej = (try_freq >= low_limit) && ({1'b0, prev_freq} == try_plus1) &&
                     (!prev_dev[DEV_SIGN_BIT] || (prev_dev > DEV_NEIGH_HI));

  assign lock_ok = !(basic_rej || above_rej || below_rej);

endmodule

### dv/fm_seek_lock_controller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fm_seek_lock_controller_test
// Self-checking regression for the FM seek and lock controller.
// ----------------------------------------------------------------------------
// A short table of directed commands and measurements runs first. It covers
// both band edges, wrap across zero, an inverted band, each level rejection,
// the neighbor rule from just above and a full circle ending in a restore.
// Random phases follow, each under its own band setting, and most of their
// items are well-formed seek sequences. An in-bench tuner model predicts all
// results; they are checked in order as they leave, both sides idling at random.
// ----------------------------------------------------------------------------
module fm_seek_lock_controller_test
  import fsl_pkg::*;
();

  // Thresholds of the lock test.
  localparam logic [3:0]  SNR_REJECT_MAX  = 4'd2;
  localparam logic [7:0]  RSSI_ACCEPT_MIN = 8'd10;
  localparam logic [11:0] DEV_REJECT_LO   = 12'd280;
  localparam logic [11:0] DEV_REJECT_HI   = 12'd3815;
  localparam logic [11:0] NEIGH_DEV_MIN   = 12'd20;
  localparam logic [11:0] NEIGH_DEV_MAX   = 12'd4075;

  localparam int PHASES           = 8;
  localparam int ITEMS_PER_PHASE  = 150;
  localparam int SETTLE_CYCLES    = 3;
  localparam int DRAIN_CYCLES     = 8;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int HOLD_AFTER       = 500;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  fsl_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  fsl_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [FREQ_W-1:0]     cfg_wdata = '0;

  fm_seek_lock_controller u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Model of the tuner: the band registers and the seek state.
  logic [FREQ_W-1:0] band_lo, band_hi;
  logic              step_mode;
  logic [FREQ_W-1:0] tuned_freq, circle_origin, probe_freq, heard_freq;
  logic              seek_active, seek_dir_down;
  logic [11:0]       heard_dev;

  // Results that the block still owes, oldest first.
  fsl_out_t    awaited_results[$];
  int unsigned mismatches = 0;
  int unsigned transfers_in = 0;

  // Knobs shared by the two sides of the handshake.
  int unsigned send_gap_pct = 20;
  int unsigned ready_stall_pct = 8;
  bit          calm_tail = 1'b0;
  bit          long_hold_done = 1'b0;

  // One row of the directed table: either a register write or an item,
  // with a hand-written expectation where the answer is obvious.
  typedef struct {
    bit                is_reg;
    cfg_idx_t          reg_idx;
    logic [FREQ_W-1:0] reg_val;
    fsl_in_t           item;
    bit                typed;
    fsl_out_t          want;
  } plan_row_t;

  plan_row_t plan[$];

  // One unit up or down, taken modulo 2^14, then folded back into the band.
  // The two folds are applied in this order, which also fixes the behavior
  // of an inverted band.
  function automatic logic [FREQ_W-1:0] next_channel(input logic [FREQ_W-1:0] f,
                                                     input logic down);
    logic [FREQ_W-1:0] n;
    n = f + (down ? {FREQ_W{1'b1}} : FREQ_W'(1));
    if (n < band_lo) n = band_hi;
    if (n > band_hi) n = band_lo;
    return n;
  endfunction

  // Lock test for the measurement of the frequency under trial. The neighbor
  // comparisons are done one bit wider so that 16383 + 1 never matches 0.
  function automatic bit station_locks(input fsl_in_t m);
    logic [FREQ_W:0] probe_wide, heard_wide;
    probe_wide = {1'b0, probe_freq};
    heard_wide = {1'b0, heard_freq};
    if (m.snr <= SNR_REJECT_MAX || m.afc_railed || m.rssi < RSSI_ACCEPT_MIN) return 1'b0;
    if (m.deviation >= DEV_REJECT_LO && m.deviation <= DEV_REJECT_HI) return 1'b0;
    if (probe_freq > band_lo && probe_wide == heard_wide + 1'b1 &&
        (heard_dev[11] || heard_dev < NEIGH_DEV_MIN)) return 1'b0;
    if (probe_freq >= band_lo && heard_wide == probe_wide + 1'b1 &&
        (!heard_dev[11] || heard_dev > NEIGH_DEV_MAX)) return 1'b0;
    return 1'b1;
  endfunction

  // Advances the model by one accepted item. Returns 1 when the item causes
  // a result, which is then left in res.
  function automatic bit tuner_advance(input fsl_in_t it, output fsl_out_t res);
    bit locked;
    res = '0;
    if (it.op == OP_MOVE) begin
      if (seek_active) return 1'b0;
      if (step_mode) begin
        tuned_freq = next_channel(tuned_freq, it.dir_down);
        res.kind   = KIND_STEP;
        res.freq   = tuned_freq;
        return 1'b1;
      end
      seek_active   = 1'b1;
      seek_dir_down = it.dir_down;
      circle_origin = tuned_freq;
      probe_freq    = next_channel(tuned_freq, it.dir_down);
      res.kind      = KIND_TUNE;
      res.freq      = probe_freq;
      return 1'b1;
    end
    if (!seek_active) return 1'b0;
    locked     = station_locks(it);
    heard_dev  = it.deviation;
    heard_freq = probe_freq;
    if (locked) begin
      tuned_freq  = probe_freq;
      seek_active = 1'b0;
      res.kind    = KIND_FOUND;
      res.freq    = tuned_freq;
    end else if (probe_freq == circle_origin) begin
      seek_active = 1'b0;
      res.kind    = KIND_RESTORE;
      res.freq    = tuned_freq;
    end else begin
      probe_freq = next_channel(probe_freq, seek_dir_down);
      res.kind   = KIND_TUNE;
      res.freq   = probe_freq;
    end
    return 1'b1;
  endfunction

  function automatic fsl_in_t pack_item(input op_t op, input logic dir, input logic [3:0] snr,
                                        input logic afc, input logic [7:0] rssi,
                                        input logic [11:0] dev);
    fsl_in_t it;
    it.op         = op;
    it.dir_down   = dir;
    it.snr        = snr;
    it.afc_railed = afc;
    it.rssi       = rssi;
    it.deviation  = dev;
    return it;
  endfunction

  function automatic void add_reg(input cfg_idx_t idx, input logic [FREQ_W-1:0] val);
    plan_row_t row;
    row         = '{reg_idx: CFG_LOW_LIMIT, default: '0};
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    plan.push_back(row);
  endfunction

  function automatic void add_item(input fsl_in_t it);
    plan_row_t row;
    row      = '{reg_idx: CFG_LOW_LIMIT, default: '0};
    row.item = it;
    plan.push_back(row);
  endfunction

  function automatic void add_checked(input fsl_in_t it, input kind_t k,
                                      input logic [FREQ_W-1:0] f);
    plan_row_t row;
    row           = '{reg_idx: CFG_LOW_LIMIT, default: '0};
    row.item      = it;
    row.typed     = 1'b1;
    row.want.kind = k;
    row.want.freq = f;
    plan.push_back(row);
  endfunction

  // Measurement with a bias toward the lock thresholds, so that both locks
  // and long rejection runs (and so restores) happen.
  function automatic fsl_in_t random_meas();
    fsl_in_t     m;
    logic [11:0] dev_edges[11];
    dev_edges = '{12'd19, 12'd20, 12'd21, 12'd279, 12'd280, 12'd2047, 12'd2048,
                  12'd3815, 12'd3816, 12'd4075, 12'd4076};
    m.op       = OP_MEAS;
    m.dir_down = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 35) begin
      m.snr        = 4'($urandom_range(3, 15));
      m.afc_railed = 1'b0;
      m.rssi       = 8'($urandom_range(10, 255));
      m.deviation  = $urandom_range(0, 1) ? 12'($urandom_range(0, 279))
                                         : 12'($urandom_range(3816, 4095));
    end else begin
      m.snr        = 4'($urandom_range(0, 15));
      m.afc_railed = 1'($urandom_range(0, 1));
      m.rssi       = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1)) m.deviation = dev_edges[$urandom_range(0, 10)];
      else m.deviation = 12'($urandom_range(0, 4095));
    end
    return m;
  endfunction

  // A move carries random junk in the measurement fields, which the block
  // must not look at.
  function automatic fsl_in_t random_move();
    fsl_in_t     it;
    logic [31:0] raw;
    raw = $urandom;
    it = raw[$bits(fsl_in_t)-1:0];
    it.op = OP_MOVE;
    return it;
  endfunction

  // Mostly what the block wants next; the rest is noise.
  function automatic fsl_in_t random_item();
    if ($urandom_range(0, 99) < 85) return seek_active ? random_meas() : random_move();
    return $urandom_range(0, 1) ? random_meas() : random_move();
  endfunction

  // Offers one item, waits for the transfer and records what it should cause.
  task automatic offer(input fsl_in_t item, input bit typed, input fsl_out_t want);
    fsl_out_t got;
    bit       produced;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_ready !== 1'b1);
    transfers_in++;
    produced = tuner_advance(item, got);
    if (typed) awaited_results.push_back(want);
    else if (produced) awaited_results.push_back(got);
    if (!calm_tail && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Register writes only go in once the block has nothing left in flight.
  // Items that cause no result leave no trace in the queue, hence the
  // short settle time after the last result.
  task automatic write_reg(input cfg_idx_t idx, input logic [FREQ_W-1:0] val);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_LOW_LIMIT:   band_lo = val;
      CFG_HIGH_LIMIT:  band_hi = val;
      CFG_MANUAL_MODE: step_mode = val[0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Sender side: reset, the directed table, then the random phases.
  initial begin : stimulus
    fsl_in_t           item;
    int                lo_pick, hi_pick;
    logic [FREQ_W-1:0] lo_val, hi_val;

    band_lo       = 14'd8750;
    band_hi       = 14'd10800;
    step_mode     = 1'b0;
    tuned_freq    = 14'd8750;
    circle_origin = '0;
    probe_freq    = '0;
    seek_active   = 1'b0;
    seek_dir_down = 1'b0;
    heard_freq    = '0;
    heard_dev     = '0;

    // Default band after reset. A measurement with no seek running is
    // dropped; a move starts a seek, and a move during a seek is dropped.
    add_item(pack_item(OP_MEAS, 1'b1, 4'd15, 1'b1, 8'd255, 12'd4095));
    add_checked(pack_item(OP_MOVE, 1'b0, 4'd0, 1'b0, 8'd0, 12'd0), KIND_TUNE, 14'd8751);
    add_item(pack_item(OP_MOVE, 1'b1, 4'd15, 1'b1, 8'd255, 12'd4095));
    add_checked(pack_item(OP_MEAS, 1'b0, 4'd15, 1'b0, 8'd255, 12'd0), KIND_FOUND, 14'd8751);
    // Seek down from just above the low edge. The first measurement sits on
    // every threshold but is refused by the neighbor rule; after the wrap to
    // the top of the band the next five fail one level test each and the last locks.
    add_checked(pack_item(OP_MOVE, 1'b1, 4'd0, 1'b0, 8'd0, 12'd0), KIND_TUNE, 14'd8750);
    add_item(pack_item(OP_MEAS, 1'b0, 4'd3, 1'b0, 8'd10, 12'd279));
    add_item(pack_item(OP_MEAS, 1'b0, 4'd2, 1'b0, 8'd255, 12'd0));
    add_item(pack_item(OP_MEAS, 1'b0, 4'd15, 1'b1, 8'd255, 12'd0));
    add_item(pack_item(OP_MEAS, 1'b0, 4'd15, 1'b0, 8'd9, 12'd0));
    add_item(pack_item(OP_MEAS, 1'b0, 4'd15, 1'b0, 8'd255, 12'd280));
    add_item(pack_item(OP_MEAS, 1'b0, 4'd15, 1'b0, 8'd255, 12'd3815));
    add_item(pack_item(OP_MEAS, 1'b0, 4'd3, 1'b0, 8'd10, 12'd3816));
    // Three-channel band: a manual step from outside lands on the low edge,
    // then a seek that never locks goes round and restores.
    add_reg(CFG_LOW_LIMIT, 14'd100);
    add_reg(CFG_HIGH_LIMIT, 14'd102);
    add_reg(CFG_MANUAL_MODE, 14'd1);
    add_checked(pack_item(OP_MOVE, 1'b0, 4'd0, 1'b0, 8'd0, 12'd0), KIND_STEP, 14'd100);
    add_reg(CFG_MANUAL_MODE, 14'd0);
    add_checked(pack_item(OP_MOVE, 1'b0, 4'd0, 1'b0, 8'd0, 12'd0), KIND_TUNE, 14'd101);
    add_item(pack_item(OP_MEAS, 1'b0, 4'd0, 1'b1, 8'd0, 12'd4095));
    add_item(pack_item(OP_MEAS, 1'b0, 4'd0, 1'b1, 8'd0, 12'd4095));
    add_checked(pack_item(OP_MEAS, 1'b0, 4'd0, 1'b1, 8'd0, 12'd4095), KIND_RESTORE, 14'd100);
    // Single-channel band at the very top.
    add_reg(CFG_LOW_LIMIT, 14'd16383);
    add_reg(CFG_HIGH_LIMIT, 14'd16383);
    add_reg(CFG_MANUAL_MODE, 14'd1);
    add_checked(pack_item(OP_MOVE, 1'b0, 4'd0, 1'b0, 8'd0, 12'd0), KIND_STEP, 14'd16383);
    // Full 14-bit range: seeks and steps wrap through zero both ways. The
    // seek down to 16383 right after a measurement at 0 must not count as
    // a neighbor, since 16383 + 1 is not 0.
    add_reg(CFG_LOW_LIMIT, 14'd0);
    add_reg(CFG_MANUAL_MODE, 14'd0);
    add_checked(pack_item(OP_MOVE, 1'b0, 4'd0, 1'b0, 8'd0, 12'd0), KIND_TUNE, 14'd0);
    add_checked(pack_item(OP_MEAS, 1'b0, 4'd15, 1'b0, 8'd255, 12'd4095), KIND_FOUND, 14'd0);
    add_item(pack_item(OP_MOVE, 1'b1, 4'd0, 1'b0, 8'd0, 12'd0));
    add_item(pack_item(OP_MEAS, 1'b0, 4'd15, 1'b0, 8'd255, 12'd0));
    add_reg(CFG_MANUAL_MODE, 14'd1);
    add_checked(pack_item(OP_MOVE, 1'b0, 4'd0, 1'b0, 8'd0, 12'd0), KIND_STEP, 14'd0);
    add_checked(pack_item(OP_MOVE, 1'b1, 4'd0, 1'b0, 8'd0, 12'd0), KIND_STEP, 14'd16383);
    // Inverted band: the low fold is applied first, then the high one.
    add_reg(CFG_LOW_LIMIT, 14'd200);
    add_reg(CFG_HIGH_LIMIT, 14'd100);
    add_item(pack_item(OP_MOVE, 1'b1, 4'd0, 1'b0, 8'd0, 12'd0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_reg) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else offer(plan[i].item, plan[i].typed, plan[i].want);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 6)
        0: begin
          lo_pick = 8750;
          hi_pick = 10800;
        end
        1: begin
          // Narrow band so that full circles and restores are common.
          lo_pick = $urandom_range(0, 16377);
          hi_pick = lo_pick + $urandom_range(0, 6);
        end
        2: begin
          lo_pick = 0;
          hi_pick = 16383;
        end
        3: begin
          hi_pick = $urandom_range(0, 16000);
          lo_pick = hi_pick + $urandom_range(1, 383);
        end
        4: begin
          lo_pick = $urandom_range(0, 16383);
          hi_pick = lo_pick;
        end
        default: begin
          lo_pick = $urandom_range(16376, 16383);
          hi_pick = 16383;
        end
      endcase
      lo_val = FREQ_W'(lo_pick);
      hi_val = FREQ_W'(hi_pick);
      write_reg(CFG_LOW_LIMIT, lo_val);
      write_reg(CFG_HIGH_LIMIT, hi_val);
      write_reg(CFG_MANUAL_MODE, (phase == 0 || $urandom_range(0, 3) != 0) ? 14'd0 : 14'd1);

      // Some phases run with no gaps at all; the last one is free of
      // idling on both sides.
      send_gap_pct    = (phase % 3 == 1) ? 0 : $urandom_range(10, 40);
      ready_stall_pct = (phase % 4 == 2) ? 0 : $urandom_range(3, 12);
      calm_tail       = (phase == PHASES - 1);

      repeat (ITEMS_PER_PHASE) begin
        item = random_item();
        offer(item, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("fm_seek_lock_controller regression: pass");
    end else begin
      $display("fm_seek_lock_controller regression: fail");
    end
    $finish;
  end

  // Receiver side. Short random stalls, plus one long hold-off while the
  // sender keeps offering, so that the output register fills and the block
  // has to stall its input.
  initial begin : result_side
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!long_hold_done && transfers_in >= HOLD_AFTER && in_valid) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm_tail && $urandom_range(0, 99) < ready_stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Every result transfer is matched against the oldest expectation.
  fsl_out_t oldest;
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result with nothing awaited: kind %0d, freq %0d", out_data.kind, out_data.freq);
        mismatches++;
      end else begin
        oldest = awaited_results.pop_front();
        if (out_data.kind !== oldest.kind) begin
          $error("kind: expected %0d, actual %0d", oldest.kind, out_data.kind);
          mismatches++;
        end
        if (out_data.freq !== oldest.freq) begin
          $error("freq: expected %0d, actual %0d", oldest.freq, out_data.freq);
          mismatches++;
        end
      end
    end
  end

  // Hard stop well past the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("fm_seek_lock_controller regression: fail");
    $finish;
  end

endmodule
